// File: sv/fsf_pkg.sv
`default_nettype none

package fsf_pkg;

  typedef enum logic [2:0] {
    REQ_NUMBER = 3'd0,
    REQ_HEX    = 3'd1,
    REQ_TIME   = 3'd2,
    REQ_TEXT   = 3'd3,
    REQ_CLEAR  = 3'd4
  } req_e;

  localparam logic [7:0] SEG_BLANK = 8'h00;
  localparam logic [7:0] SEG_MINUS = 8'h40;

  // index 0 is glyph '0', index 15 is glyph 'F'
  localparam logic [15:0][7:0] SEG_TABLE = {
    8'h71, 8'h79, 8'h5e, 8'h39, 8'h7c, 8'h77, 8'h6f, 8'h7f,
    8'h07, 8'h7d, 8'h6d, 8'h66, 8'h4f, 8'h5b, 8'h06, 8'h3f
  };

  localparam logic signed [15:0] NUM_MIN = -16'sd999;
  localparam logic signed [15:0] NUM_MAX = 16'sd9999;

  localparam logic [4:0] HOURS_MAX   = 5'd23;
  localparam logic [5:0] MINUTES_MAX = 6'd59;
  localparam logic [2:0] TEXT_MAX    = 3'd4;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_QUEST   = 8'h3f;

  typedef struct packed {
    logic [2:0]        req_type;
    logic signed [15:0] number_value;
    logic [15:0]       hex_value;
    logic [4:0]        hours;
    logic [5:0]        minutes;
    logic [3:0][7:0]   text_char;
    logic [2:0]        text_length;
  } req_t;

  // pat[0] is the leftmost digit
  typedef struct packed {
    logic [3:0][7:0] pat;
    logic            colon;
  } disp_t;

  function automatic logic [7:0] hex_seg(input logic [3:0] d);
    return SEG_TABLE[d];
  endfunction

  function automatic logic [7:0] char_seg(input logic [7:0] c);
    logic [7:0] res;
    res = SEG_BLANK;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      res = SEG_TABLE[c[3:0]];
    end else if ((c >= CH_UPPER_A && c <= CH_UPPER_F) ||
                 (c >= CH_LOWER_A && c <= CH_LOWER_F)) begin
      res = SEG_TABLE[4'(c[3:0] + 4'd9)];
    end else if (c == CH_MINUS) begin
      res = SEG_MINUS;
    end
    return res;
  endfunction

  function automatic logic [7:0] seg_char(input logic [7:0] p);
    logic [7:0] res;
    if (p[6:0] == SEG_MINUS[6:0]) begin
      res = CH_MINUS;
    end else if (p[6:0] == SEG_BLANK[6:0]) begin
      res = CH_SPACE;
    end else begin
      res = CH_QUEST;
    end
    for (int i = 15; i >= 0; i--) begin
      if (SEG_TABLE[i][6:0] == p[6:0]) begin
        res = (i < 10) ? 8'(CH_ZERO + 8'(i)) : 8'(CH_UPPER_A + 8'(i - 10));
      end
    end
    return res;
  endfunction

  // reciprocal multiplies, exact for n below 10000
  function automatic logic [13:0] div10(input logic [13:0] n);
    logic [30:0] prod;
    prod = 31'(n) * 31'd52429;
    return 14'(prod[30:19]);
  endfunction

  function automatic logic [13:0] div100(input logic [13:0] n);
    logic [26:0] prod;
    prod = 27'(n) * 27'd5243;
    return 14'(prod[26:19]);
  endfunction

  function automatic logic [13:0] div1000(input logic [13:0] n);
    logic [27:0] prod;
    prod = 28'(n) * 28'd8389;
    return 14'(prod[27:23]);
  endfunction

endpackage

`default_nettype wire

// File: sv/fsf_req_if.sv
`default_nettype none

interface fsf_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic signed [15:0] number_value;
  logic [15:0]        hex_value;
  logic [4:0]         hours;
  logic [5:0]         minutes;
  logic [7:0]         text_char_0;
  logic [7:0]         text_char_1;
  logic [7:0]         text_char_2;
  logic [7:0]         text_char_3;
  logic [2:0]         text_length;

  modport source (
    output valid, req_type, number_value, hex_value, hours, minutes,
           text_char_0, text_char_1, text_char_2, text_char_3, text_length,
    input  ready
  );

  modport sink (
    input  valid, req_type, number_value, hex_value, hours, minutes,
           text_char_0, text_char_1, text_char_2, text_char_3, text_length,
    output ready
  );
endinterface

`default_nettype wire

// File: sv/fsf_rsp_if.sv
`default_nettype none

interface fsf_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] pattern_0;
  logic [7:0] pattern_1;
  logic [7:0] pattern_2;
  logic [7:0] pattern_3;
  logic       colon_on;
  logic       status;
  logic [7:0] glyph_0;
  logic [7:0] glyph_1;
  logic [7:0] glyph_2;
  logic [7:0] glyph_3;

  modport source (
    output valid, pattern_0, pattern_1, pattern_2, pattern_3, colon_on, status,
           glyph_0, glyph_1, glyph_2, glyph_3,
    input  ready
  );

  modport sink (
    input  valid, pattern_0, pattern_1, pattern_2, pattern_3, colon_on, status,
           glyph_0, glyph_1, glyph_2, glyph_3,
    output ready
  );
endinterface

`default_nettype wire

// File: sv/four_digit_seven_segment_formatter.sv
// a taken request beat waits in the input register; its result is offered from the result register once that is free
// throughput: one request per cycle while results are taken, set by a single register-to-register pass
// the display state updates in the same cycle the result register loads
// reset: asynchronous, active low; clears the display to blank, colon off,
// and empties the input and result registers
`default_nettype none

module four_digit_seven_segment_formatter
  import fsf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  fsf_req_if.sink    req_i,
  fsf_rsp_if.source  rsp_o
);

  logic            in_valid_q;
  req_t            req_q;
  req_t            req_in;
  logic            out_valid_q;
  logic            out_free;
  logic            advance;
  logic            in_ready;
  disp_t           disp_q;
  disp_t           disp_d;
  logic            status_q;
  logic            status_d;
  logic [3:0][7:0] glyph_q;
  logic [3:0][7:0] glyph_d;

  assign req_in = '{
    req_type:     req_i.req_type,
    number_value: req_i.number_value,
    hex_value:    req_i.hex_value,
    hours:        req_i.hours,
    minutes:      req_i.minutes,
    text_char:    {req_i.text_char_3, req_i.text_char_2,
                   req_i.text_char_1, req_i.text_char_0},
    text_length:  req_i.text_length
  };

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign advance     = in_valid_q && out_free;
  assign in_ready    = !in_valid_q || advance;
  assign req_i.ready = in_ready;

  fsf_encode u_encode (
    .req_i    (req_q),
    .cur_i    (disp_q),
    .nxt_o    (disp_d),
    .status_o (status_d)
  );

  fsf_glyph u_glyph (
    .pat_i   (disp_d.pat),
    .glyph_o (glyph_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      disp_q      <= '0;
    end else begin
      if (in_ready) begin
        in_valid_q <= req_i.valid;
      end
      if (out_free) begin
        out_valid_q <= advance;
      end
      if (advance) begin
        disp_q <= disp_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && in_ready) begin
      req_q <= req_in;
    end
    if (advance) begin
      status_q <= status_d;
      glyph_q  <= glyph_d;
    end
  end

  // the result pattern always equals the stored display
  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.pattern_0 = disp_q.pat[0];
  assign rsp_o.pattern_1 = disp_q.pat[1];
  assign rsp_o.pattern_2 = disp_q.pat[2];
  assign rsp_o.pattern_3 = disp_q.pat[3];
  assign rsp_o.colon_on  = disp_q.colon;
  assign rsp_o.status    = status_q;
  assign rsp_o.glyph_0   = glyph_q[0];
  assign rsp_o.glyph_1   = glyph_q[1];
  assign rsp_o.glyph_2   = glyph_q[2];
  assign rsp_o.glyph_3   = glyph_q[3];

endmodule

`default_nettype wire

// File: sv/fsf_encode.sv
`default_nettype none

module fsf_encode
  import fsf_pkg::*;
(
  input  req_t  req_i,
  input  disp_t cur_i,
  output disp_t nxt_o,
  output logic  status_o
);

  logic signed [15:0] clamped;
  logic               neg;
  logic [13:0]        mag;
  logic [13:0]        q1, q2, q3;
  logic [3:0]         d0, d1, d2, d3;
  logic [3:0][7:0]    num_pat;
  logic [3:0][7:0]    hex_pat;
  logic [3:0][7:0]    time_pat;
  logic [3:0][7:0]    text_pat;
  logic [13:0]        hq, mq;
  logic               time_err;
  logic [2:0]         len;

  // decimal
  always_comb begin
    if (req_i.number_value < NUM_MIN) begin
      clamped = NUM_MIN;
    end else if (req_i.number_value > NUM_MAX) begin
      clamped = NUM_MAX;
    end else begin
      clamped = req_i.number_value;
    end
    neg = clamped[15];
    mag = neg ? 14'(-clamped) : 14'(clamped);
    q1  = div10(mag);
    q2  = div100(mag);
    q3  = div1000(mag);
    d0  = 4'(mag - 14'(q1 * 14'd10));
    d1  = 4'(q1 - 14'(q2 * 14'd10));
    d2  = 4'(q2 - 14'(q3 * 14'd10));
    d3  = 4'(q3);

    num_pat    = {4{SEG_BLANK}};
    num_pat[3] = hex_seg(d0);
    if (mag >= 14'd10)   num_pat[2] = hex_seg(d1);
    if (mag >= 14'd100)  num_pat[1] = hex_seg(d2);
    if (mag >= 14'd1000) num_pat[0] = hex_seg(d3);
    // minus sits just left of the leading digit
    if (neg) begin
      if (mag >= 14'd100) begin
        num_pat[0] = SEG_MINUS;
      end else if (mag >= 14'd10) begin
        num_pat[1] = SEG_MINUS;
      end else begin
        num_pat[2] = SEG_MINUS;
      end
    end
  end

  // hex
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      hex_pat[i] = hex_seg(req_i.hex_value[4*(3-i) +: 4]);
    end
  end

  // time
  always_comb begin
    time_err    = (req_i.hours > HOURS_MAX) || (req_i.minutes > MINUTES_MAX);
    hq          = div10(14'(req_i.hours));
    mq          = div10(14'(req_i.minutes));
    time_pat[0] = hex_seg(4'(hq));
    time_pat[1] = hex_seg(4'(14'(req_i.hours) - 14'(hq * 14'd10)));
    time_pat[2] = hex_seg(4'(mq));
    time_pat[3] = hex_seg(4'(14'(req_i.minutes) - 14'(mq * 14'd10)));
  end

  // text
  always_comb begin
    len = (req_i.text_length > TEXT_MAX) ? TEXT_MAX : req_i.text_length;
    for (int i = 0; i < 4; i++) begin
      text_pat[i] = (3'(i) < len) ? char_seg(req_i.text_char[i]) : SEG_BLANK;
    end
  end

  always_comb begin
    nxt_o    = cur_i;
    status_o = 1'b0;
    unique case (req_e'(req_i.req_type))
      REQ_NUMBER: begin
        nxt_o = '{pat: num_pat, colon: 1'b0};
      end
      REQ_HEX: begin
        nxt_o = '{pat: hex_pat, colon: 1'b0};
      end
      REQ_TIME: begin
        if (time_err) begin
          status_o = 1'b1;
        end else begin
          nxt_o = '{pat: time_pat, colon: 1'b1};
        end
      end
      REQ_TEXT: begin
        nxt_o = '{pat: text_pat, colon: 1'b0};
      end
      REQ_CLEAR: begin
        nxt_o = '{pat: {4{SEG_BLANK}}, colon: 1'b0};
      end
      default: begin
        nxt_o = cur_i;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: sv/fsf_glyph.sv
`default_nettype none

module fsf_glyph
  import fsf_pkg::*;
(
  input  logic [3:0][7:0] pat_i,
  output logic [3:0][7:0] glyph_o
);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      glyph_o[i] = seg_char(pat_i[i]);
    end
  end

endmodule

`default_nettype wire
